// ===== sv/assert_macros.svh =====
// assertion macros shared by the line assembler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LIA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("line assembler assertion failed");

// consequent checked in the cycle after the trigger
`define LIA_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("line assembler assertion failed");

`endif

// ===== sv/lia_pkg.sv =====
// types and constants of the line input assembler
`timescale 1ns / 1ps
`default_nettype none

package lia_pkg;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TERM    = 2'd1,
        CAUSE_FULL    = 2'd2,
        CAUSE_TIMEOUT = 2'd3
    } t_cause;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_TERM    = 1'b1;

    localparam logic [7:0] BS_CODE         = 8'd8;
    localparam logic [7:0] DEL_CODE        = 8'd127;
    localparam logic [7:0] TIMEOUT_DEFAULT = 8'd150;
    localparam logic [7:0] TERM_DEFAULT    = 8'd13;
    localparam logic [7:0] IDLE_MAX        = 8'hFF;

    typedef struct packed {
        logic       line_done;
        logic [5:0] line_length;
        t_cause     end_cause;
        logic       hit;
    } t_stage;

    typedef struct packed {
        logic       line_done;
        logic [5:0] line_length;
        t_cause     end_cause;
        logic [7:0] read_char;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/lia_req_if.sv =====
// request channel of the line input assembler
`timescale 1ns / 1ps
`default_nettype none

interface lia_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic [5:0] read_index;

    modport source (output valid, output req_type, output byte_value, output read_index,
                    input ready);
    modport sink (input valid, input req_type, input byte_value, input read_index,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/lia_res_if.sv =====
// result channel of the line input assembler
`timescale 1ns / 1ps
`default_nettype none

interface lia_res_if;
    logic       valid;
    logic       ready;
    logic       line_done;
    logic [5:0] line_length;
    logic [1:0] end_cause;
    logic [7:0] read_char;

    modport source (output valid, output line_done, output line_length, output end_cause,
                    output read_char, input ready);
    modport sink (input valid, input line_done, input line_length, input end_cause,
                  input read_char, output ready);
endinterface

`default_nettype wire

// ===== sv/line_input_assembler.sv =====
// line input assembler top level
// an accepted item passes stage register r_s1, then output register r_res, before its result can be taken
// throughput: one item per cycle unless the output stalls; the store is read or written at most once per item
// a read item reads the store when accepted; the registered store output holds until the item moves on
// reset: synchronous active low, line ended and empty, default timeout and terminator
// store contents are not cleared by reset; entries below the length are always written
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_input_assembler #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lia_req_if.sink         i_req,
    lia_res_if.source       o_res,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int XW = AW + 7;
    localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

    logic [7:0]      r_timeout;
    logic [7:0]      r_term;
    logic [AW-1:0]   r_count, n_count;
    logic            r_ended, n_ended;
    logic [7:0]      r_idle, n_idle;
    lia_pkg::t_cause r_cause, n_cause;

    logic            r_v1;
    lia_pkg::t_stage r_s1, n_s1;
    logic            r_vo;
    lia_pkg::t_result r_res;

    logic            acc;
    logic            mv1;
    logic            mem_we;
    logic            mem_re;
    logic [7:0]      mem_rdata;
    logic [7:0]      idle_inc;
    lia_pkg::t_req   req;

    assign req = lia_pkg::t_req'(i_req.req_type);
    assign mv1 = !r_vo || o_res.ready;
    assign i_req.ready = !r_v1 || mv1;
    assign acc = i_req.valid && i_req.ready;
    assign idle_inc = (r_idle != lia_pkg::IDLE_MAX) ? r_idle + 8'd1 : r_idle;

    always_comb begin
        n_count = r_count;
        n_ended = r_ended;
        n_idle  = r_idle;
        n_cause = r_cause;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        case (req)
            lia_pkg::REQ_START: begin
                n_count = '0;
                n_idle  = '0;
                n_ended = 1'b0;
                n_cause = lia_pkg::CAUSE_NONE;
            end
            lia_pkg::REQ_BYTE: begin
                if (!r_ended) begin
                    n_idle = '0;
                    if (i_req.byte_value == r_term) begin
                        n_ended = 1'b1;
                        n_cause = lia_pkg::CAUSE_TERM;
                    end else if (r_count >= LAST) begin
                        n_ended = 1'b1;
                        n_cause = lia_pkg::CAUSE_FULL;
                    end else if (i_req.byte_value == lia_pkg::BS_CODE ||
                                 i_req.byte_value == lia_pkg::DEL_CODE) begin
                        if (r_count != '0) begin
                            n_count = r_count - AW'(1);
                        end
                    end else begin
                        mem_we  = acc;
                        n_count = r_count + AW'(1);
                    end
                end
            end
            lia_pkg::REQ_TICK: begin
                if (!r_ended) begin
                    n_idle = idle_inc;
                    if (idle_inc >= r_timeout) begin
                        n_ended = 1'b1;
                        n_cause = lia_pkg::CAUSE_TIMEOUT;
                    end
                end
            end
            lia_pkg::REQ_READ: begin
                mem_re = acc;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
        n_s1.line_done   = n_ended;
        n_s1.line_length = 6'(n_count);
        n_s1.end_cause   = n_cause;
        n_s1.hit         = (req == lia_pkg::REQ_READ) &&
                           (XW'(i_req.read_index) < XW'(r_count));
    end

    lia_line_mem #(
        .DEPTH (LINE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count),
        .i_wdata (i_req.byte_value),
        .i_re    (mem_re),
        .i_raddr (AW'(i_req.read_index)),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= lia_pkg::TIMEOUT_DEFAULT;
            r_term    <= lia_pkg::TERM_DEFAULT;
            r_count   <= '0;
            r_ended   <= 1'b1;
            r_idle    <= '0;
            r_cause   <= lia_pkg::CAUSE_NONE;
            r_v1      <= 1'b0;
            r_vo      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lia_pkg::CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else begin
                    r_term <= i_cfg_data;
                end
            end
            if (acc) begin
                r_count <= n_count;
                r_ended <= n_ended;
                r_idle  <= n_idle;
                r_cause <= n_cause;
            end
            if (acc) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_vo <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (mv1 && r_v1) begin
            r_res.line_done   <= r_s1.line_done;
            r_res.line_length <= r_s1.line_length;
            r_res.end_cause   <= r_s1.end_cause;
            r_res.read_char   <= r_s1.hit ? mem_rdata : 8'd0;
        end
    end

    assign o_res.valid       = r_vo;
    assign o_res.line_done   = r_res.line_done;
    assign o_res.line_length = r_res.line_length;
    assign o_res.end_cause   = r_res.end_cause;
    assign o_res.read_char   = r_res.read_char;

    `LIA_ASSERT(a_count_bound, r_count <= LAST)
    `LIA_ASSERT_NEXT(a_start_clears, acc && req == lia_pkg::REQ_START,
        !r_ended && r_count == '0 && r_idle == '0)
    `LIA_ASSERT_NEXT(a_full_ends, acc && req == lia_pkg::REQ_BYTE && !r_ended &&
        i_req.byte_value != r_term && r_count == LAST,
        r_ended && r_cause == lia_pkg::CAUSE_FULL && r_count == LAST)
    `LIA_ASSERT_NEXT(a_stall_holds, r_v1 && !mv1, r_v1 && $stable(r_s1))

endmodule

`default_nettype wire

// ===== sv/lia_line_mem.sv =====
// character store with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module lia_line_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
